/* design/icfcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfcm_pkg: shared types and constants of the instruction cache cost model
// Fetch address width, line geometry, miss costs and the result record.
// ----------------------------------------------------------------------------
package icfcm_pkg;

   // fetch word address width
   localparam int ADDR_W = 30;

   // four words to a line
   localparam int LINE_WORDS = 4;
   localparam int OFF_W      = 2;

   // cycle charge width and costs
   localparam int CYC_W = 3;
   localparam logic [CYC_W-1:0] MISS_BASE_COST = 3'd3;
   localparam logic [CYC_W-1:0] UNCACHED_COST  = 3'd4;

   // first word address of the uncached region (byte address 0xA0000000)
   localparam logic [ADDR_W-1:0] UNCACHED_WORD = 30'h2800_0000;

   // one result item
   typedef struct packed {
      logic             hit;
      logic             clear_load_giveback;
      logic             uncached;
      logic [CYC_W-1:0] extra_cycles;
   } rsp_type;

endpackage

/* design/icfcm_tag_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfcm_tag_ram: line-wide tag store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module icfcm_tag_ram #(
   parameter int DEPTH  = 256,
   parameter int LINE_W = 8,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [LINE_W-1:0] wr_line,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [LINE_W-1:0] rd_line,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write one line
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_line] <= wr_data;
      end
   end

   // read one line, old data on a same-edge write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_line];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/icfcm_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfcm_lookup: hit check, miss classification and refill entry
// Compares the fetched line against the address and builds the result item
// and the new line contents on a cached miss.
// ----------------------------------------------------------------------------
module icfcm_lookup #(
   parameter int IDX_W = 10,
   parameter int TAG_W = 20
) (
   input  logic                                 enable,
   input  logic [icfcm_pkg::ADDR_W-1:0]         addr,
   input  logic [TAG_W+icfcm_pkg::LINE_WORDS-1:0] entry,
   output icfcm_pkg::rsp_type                   rsp,
   output logic                                 wr_en,
   output logic [TAG_W+icfcm_pkg::LINE_WORDS-1:0] wr_entry
);

   import icfcm_pkg::*;

   logic [TAG_W-1:0]      tag;
   logic [OFF_W-1:0]      off;
   logic [LINE_WORDS-1:0] line_valid;
   logic [TAG_W-1:0]      line_tag;
   logic                  match;
   logic                  in_uncached;
   logic [CYC_W-1:0]      fill_count;
   logic [LINE_WORDS-1:0] fill_mask;

   // split address and stored line
   assign tag        = addr[ADDR_W-1:IDX_W];
   assign off        = addr[OFF_W-1:0];
   assign line_valid = entry[TAG_W+LINE_WORDS-1:TAG_W];
   assign line_tag   = entry[TAG_W-1:0];

   assign match       = line_valid[off] && (line_tag == tag);
   assign in_uncached = (addr >= UNCACHED_WORD);

   // words from the fetch offset to the end of the line become valid
   assign fill_count = CYC_W'(LINE_WORDS) - CYC_W'(off);
   assign fill_mask  = LINE_WORDS'({LINE_WORDS{1'b1}} << off);

   // classify the item
   always_comb begin
      rsp      = '0;
      wr_en    = 1'b0;
      wr_entry = {fill_mask, tag};
      if (enable) begin
         if (match) begin
            rsp.hit = 1'b1;
         end else begin
            rsp.clear_load_giveback = 1'b1;
            if (in_uncached) begin
               rsp.uncached     = 1'b1;
               rsp.extra_cycles = UNCACHED_COST;
            end else begin
               rsp.extra_cycles = MISS_BASE_COST + fill_count;
               wr_en            = 1'b1;
            end
         end
      end
   end

endmodule

/* design/icache_fetch_cost_model_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icache_fetch_cost_model_core: direct-mapped instruction cache cost model
// Looks up each fetch in a line-wide tag store, refills on a cached miss and
// reports hit, miss kind and the cycles charged.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------
//   request   start, busy, req_*             taken when start and not busy
//   result    rsp_strobe, rsp_*              one cycle, cannot be held off
//   config    csr_write_enable, csr_*        written when enable is high
//
// One item per cycle while busy is low; its result reaches the result ports
// through the tag store read and item capture at the taking edge, then the
// compare into the result register.
// A same-line refill from the previous item is forwarded past the store.
// After reset a clearing pass over every tag store line holds busy high.
// The result side has no stall, so busy depends only on the clearing pass.
// ----------------------------------------------------------------------------
module icache_fetch_cost_model_core #(
   parameter int CACHE_WORDS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [icfcm_pkg::ADDR_W-1:0]          req_fetch_word_address,
   output logic                                  rsp_strobe,
   output logic                                  rsp_hit,
   output logic                                  rsp_clear_load_giveback,
   output logic                                  rsp_uncached,
   output logic [icfcm_pkg::CYC_W-1:0]           rsp_extra_cycles,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_write_data
);

   import icfcm_pkg::*;

   localparam int IDX_W   = $clog2(CACHE_WORDS);
   localparam int TAG_W   = ADDR_W - IDX_W;
   localparam int LINES   = CACHE_WORDS / LINE_WORDS;
   localparam int LINE_W  = IDX_W - OFF_W;
   localparam int ENTRY_W = TAG_W + LINE_WORDS;

   // clearing pass
   logic              clr_active_ff, clr_active_in;
   logic [LINE_W-1:0] clr_line_ff, clr_line_in;
   logic              clr_last;

   // configuration
   logic              cache_enable_ff, cache_enable_in;

   // lookup stage
   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [LINE_W-1:0] s1_line;

   // refill forwarding
   logic               fwd_valid_ff, fwd_valid_in;
   logic [LINE_W-1:0]  fwd_line_ff, fwd_line_in;
   logic [ENTRY_W-1:0] fwd_entry_ff, fwd_entry_in;

   // result register
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [LINE_W-1:0]  rd_line;
   logic [ENTRY_W-1:0] rd_entry;
   logic [ENTRY_W-1:0] cur_entry;
   logic               lk_wr_en;
   logic [ENTRY_W-1:0] lk_wr_entry;
   logic               item_write;
   logic               ram_wr_en;
   logic [LINE_W-1:0]  ram_wr_line;
   logic [ENTRY_W-1:0] ram_wr_data;

   assign busy   = clr_active_ff;
   assign accept = start && !busy;

   // advance the clearing pass one line a cycle
   assign clr_last      = (clr_line_ff == LINE_W'(LINES - 1));
   assign clr_active_in = clr_active_ff && !clr_last;
   assign clr_line_in   = clr_active_ff ? clr_line_ff + 1'b1 : clr_line_ff;

   // take configuration writes
   assign cache_enable_in = csr_write_enable ? csr_write_data : cache_enable_ff;

   // capture the accepted item
   assign s1_valid_in = accept;
   assign s1_addr_in  = accept ? req_fetch_word_address : s1_addr_ff;
   assign rd_line     = req_fetch_word_address[IDX_W-1:OFF_W];
   assign s1_line     = s1_addr_ff[IDX_W-1:OFF_W];

   // take a refill of the same line from the previous item over the store read
   assign cur_entry = (fwd_valid_ff && (fwd_line_ff == s1_line)) ? fwd_entry_ff : rd_entry;

   icfcm_lookup #(
      .IDX_W (IDX_W),
      .TAG_W (TAG_W)
   ) u_lookup (
      .enable   (cache_enable_ff),
      .addr     (s1_addr_ff),
      .entry    (cur_entry),
      .rsp      (rsp_in),
      .wr_en    (lk_wr_en),
      .wr_entry (lk_wr_entry)
   );

   assign item_write = s1_valid_ff && lk_wr_en;

   // hold the last refill for forwarding
   assign fwd_valid_in = item_write;
   assign fwd_line_in  = item_write ? s1_line : fwd_line_ff;
   assign fwd_entry_in = item_write ? lk_wr_entry : fwd_entry_ff;

   // store write: clearing pass or refill
   assign ram_wr_en   = clr_active_ff || item_write;
   assign ram_wr_line = clr_active_ff ? clr_line_ff : s1_line;
   assign ram_wr_data = clr_active_ff ? '0 : lk_wr_entry;

   icfcm_tag_ram #(
      .DEPTH  (LINES),
      .LINE_W (LINE_W),
      .DATA_W (ENTRY_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_line (ram_wr_line),
      .wr_data (ram_wr_data),
      .rd_line (rd_line),
      .rd_data (rd_entry)
   );

   assign rsp_strobe_in = s1_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff   <= 1'b1;
         clr_line_ff     <= '0;
         cache_enable_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         clr_active_ff   <= clr_active_in;
         clr_line_ff     <= clr_line_in;
         cache_enable_ff <= cache_enable_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_addr_ff   <= s1_addr_in;
      fwd_line_ff  <= fwd_line_in;
      fwd_entry_ff <= fwd_entry_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe              = rsp_strobe_ff;
   assign rsp_hit                 = rsp_ff.hit;
   assign rsp_clear_load_giveback = rsp_ff.clear_load_giveback;
   assign rsp_uncached            = rsp_ff.uncached;
   assign rsp_extra_cycles        = rsp_ff.extra_cycles;

endmodule
